FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is low.
`define QBSPE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds at a clock edge.
`define QBSPE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `QBSPE_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/qbspe_pkg.sv
package qbspe_pkg;

  // Request function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Depth of the result queue; results in flight are bounded by it.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned OUT_CNT_W = 3;

  // Which of the three span points a memory access belongs to.
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_MID,
    PH_LAST
  } phase_e;

  // Control that travels with point data down the blend pipeline.
  typedef struct packed {
    logic   vld;
    phase_e ph;
    logic   clamp;
  } tag_t;

  // One control point: index 0 is x, 1 is y, 2 is z.
  typedef logic [2:0][31:0] point_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic             clamped;
  } res_t;

endpackage

FILE: rtl/quadratic_bspline_point_eval_unit.sv
// Channel   Direction  Handshake                  Payload
// in        request    in_valid_i / in_stall_o    func, point_index, coord_x/y/z, param_t
// out       result     out_valid_o / out_stall_i  pos_x/y/z, t_clamped
// cfg       write      cfg_we_i                   cfg_wdata_i (num_points)
//
// An evaluate request holds the single point memory port for one read per span point;
// a load request holds it for its write.
// After its reads, a result passes the rdata, data, product and accumulator registers.
// Reset clears the control state and sets num_points to 3; the point memory is not
// cleared, no sweep needed: the user must load points before use, unchecked by the block.
// Results wait in a four-entry queue; the input stalls while the memory port is busy
// or while four results are queued or in flight.
`include "assert_macros.svh"

module quadratic_bspline_point_eval_unit #(
  parameter int MAX_POINTS = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [8:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [7:0]         point_index_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [23:0]        param_t_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic               t_clamped_o
);
  import qbspe_pkg::*;

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int WW  = (FRAC_BITS + 9 > 24) ? FRAC_BITS + 9 : 24;
  localparam int XW  = 2 * FRAC_BITS + 3;
  localparam int WBW = FRAC_BITS + 3;
  localparam int PW  = 32 + WBW;
  localparam int SW  = PW + 2;

  localparam logic [FRAC_BITS:0]   ONE     = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS+1:0] TWO_ONE = {ONE, 1'b0};
  localparam logic signed [SW-1:0] HALF    = SW'(ONE >> 1);

  function automatic logic [31:0] round_sat(logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + HALF) >>> FRAC_BITS;
    if (r[SW-1:31] != {(SW - 31){r[SW-1]}}) begin
      return r[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return r[31:0];
  endfunction

  // Configuration.
  logic [8:0] num_points_q;

  // Issue stage: owns the point memory port.
  logic           iss_vld_q;
  phase_e         iss_ph_q;
  logic           iss_func_q;
  logic [7:0]     iss_idx_q;
  point_t         iss_pt_q;
  logic [AW-1:0]  iss_s_q;
  logic [FRAC_BITS:0] iss_u_q;
  logic           iss_first_q;
  logic           iss_last_q;
  logic           iss_clamp_q;

  // Weights.
  logic [XW-1:0]         xw_q, zw_q;
  logic signed [WBW-1:0] bx_q, by_q, bz_q;

  // Blend pipeline.
  point_t               mem_q [MAX_POINTS];
  point_t               rdata_q;
  tag_t                 rd_tag_q;
  point_t               dat_q;
  tag_t                 dat_tag_q;
  logic signed [PW-1:0] prod_q [3];
  tag_t                 prod_tag_q;
  logic signed [SW-1:0] acc_q [3];
  logic                 fin_q;
  logic                 fin_clamp_q;

  // Result queue and result credit.
  res_t                 fifo_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0] cnt_q, infl_q;

  // Request decode: segment and local parameter of the span.
  logic [8:0]         n_eff;
  logic [WW-1:0]      t_w, dend_w, tc_w, seg_w;
  logic               clamp_w, at_end_w;
  logic [AW-1:0]      s_w;
  logic [FRAC_BITS:0] u_w;

  always_comb begin
    if (num_points_q < 9'd3) begin
      n_eff = 9'd3;
    end else if (32'(num_points_q) > 32'(MAX_POINTS)) begin
      n_eff = 9'(MAX_POINTS);
    end else begin
      n_eff = num_points_q;
    end
    t_w      = WW'(param_t_i);
    dend_w   = WW'(n_eff - 9'd2) << FRAC_BITS;
    clamp_w  = t_w > dend_w;
    tc_w     = clamp_w ? dend_w : t_w;
    seg_w    = tc_w >> FRAC_BITS;
    at_end_w = seg_w >= WW'(n_eff - 9'd2);
    s_w      = at_end_w ? AW'(n_eff - 9'd3) : AW'(seg_w);
    u_w      = at_end_w ? ONE : {1'b0, tc_w[FRAC_BITS-1:0]};
  end

  // Handshake and credit.
  logic in_acc, eval_acc, iss_done, credit_full, push, pop;

  assign iss_done    = iss_vld_q && (iss_func_q == FUNC_LOAD || iss_ph_q == PH_LAST);
  assign credit_full = ({1'b0, infl_q} + {1'b0, cnt_q}) >= (OUT_CNT_W + 1)'(OUT_DEPTH);
  assign in_stall_o  = (iss_vld_q && !iss_done) || credit_full;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign eval_acc    = in_acc && func_i == FUNC_EVAL;
  assign push        = fin_q;
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= 9'd3;
    end else if (cfg_we_i) begin
      num_points_q <= cfg_wdata_i;
    end
  end

  // Issue stage control.
  phase_e iss_ph_d;

  always_comb begin
    case (iss_ph_q)
      PH_FIRST: iss_ph_d = PH_MID;
      PH_MID:   iss_ph_d = PH_LAST;
      default:  iss_ph_d = PH_FIRST;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_vld_q <= 1'b0;
      iss_ph_q  <= PH_FIRST;
    end else if (in_acc) begin
      iss_vld_q <= 1'b1;
      iss_ph_q  <= PH_FIRST;
    end else if (iss_done) begin
      iss_vld_q <= 1'b0;
      iss_ph_q  <= PH_FIRST;
    end else if (iss_vld_q) begin
      iss_ph_q  <= iss_ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      iss_func_q  <= func_i;
      iss_idx_q   <= point_index_i;
      iss_pt_q    <= {coord_z_i, coord_y_i, coord_x_i};
      iss_s_q     <= s_w;
      iss_u_q     <= u_w;
      iss_first_q <= s_w == '0;
      iss_last_q  <= s_w == AW'(n_eff - 9'd3);
      iss_clamp_q <= clamp_w;
    end
  end

  // Basis weights over the denominator 2*ONE*ONE, formed during the first read,
  // then scaled to ONE during the second.
  logic [FRAC_BITS+1:0]  a_w, b_w, ta_w;
  logic [FRAC_BITS:0]    ome_w;
  logic [XW-1:0]         x_w, z_w, xr_w, zr_w;
  logic signed [WBW-1:0] bx_w, by_w, bz_w;
  logic                  iss_eval;

  assign iss_eval = iss_vld_q && iss_func_q == FUNC_EVAL;

  always_comb begin
    a_w   = iss_first_q ? {iss_u_q, 1'b0} : (FRAC_BITS + 2)'(iss_u_q) + (FRAC_BITS + 2)'(ONE);
    b_w   = iss_last_q ? {iss_u_q, 1'b0} : {1'b0, iss_u_q};
    ta_w  = TWO_ONE - a_w;
    ome_w = ONE - iss_u_q;
    x_w   = XW'(ome_w) * XW'(ta_w);
    z_w   = XW'(iss_u_q) * XW'(b_w);
    xr_w  = xw_q + XW'(ONE);
    zr_w  = zw_q + XW'(ONE);
    bx_w  = $signed(WBW'(xr_w >> (FRAC_BITS + 1)));
    bz_w  = $signed(WBW'(zr_w >> (FRAC_BITS + 1)));
    by_w  = $signed(WBW'(ONE)) - bx_w - bz_w;
  end

  always_ff @(posedge clk_i) begin
    if (iss_eval && iss_ph_q == PH_FIRST) begin
      xw_q <= x_w;
      zw_q <= z_w;
    end
    if (iss_eval && iss_ph_q == PH_MID) begin
      bx_q <= bx_w;
      by_q <= by_w;
      bz_q <= bz_w;
    end
  end

  // Single-port point memory.
  logic [AW-1:0] mem_addr;
  logic          mem_we;

  assign mem_addr = (iss_func_q == FUNC_LOAD) ? AW'(iss_idx_q) : iss_s_q + AW'(iss_ph_q);
  assign mem_we   = iss_vld_q && iss_func_q == FUNC_LOAD &&
                    32'(iss_idx_q) < 32'(MAX_POINTS);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= iss_pt_q;
    end
    rdata_q <= mem_q[mem_addr];
  end

  // Blend: one point per cycle, three lanes multiply and accumulate.
  logic signed [WBW-1:0] w_sel;

  always_comb begin
    case (dat_tag_q.ph)
      PH_FIRST: w_sel = bx_q;
      PH_MID:   w_sel = by_q;
      default:  w_sel = bz_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_tag_q   <= '0;
      dat_tag_q  <= '0;
      prod_tag_q <= '0;
      fin_q      <= 1'b0;
    end else begin
      rd_tag_q   <= '{vld: iss_eval, ph: iss_ph_q, clamp: iss_clamp_q};
      dat_tag_q  <= rd_tag_q;
      prod_tag_q <= dat_tag_q;
      fin_q      <= prod_tag_q.vld && prod_tag_q.ph == PH_LAST;
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q <= rdata_q;
    for (int i = 0; i < 3; i++) begin
      prod_q[i] <= PW'($signed(dat_q[i])) * PW'(w_sel);
      if (prod_tag_q.vld) begin
        acc_q[i] <= (prod_tag_q.ph == PH_FIRST) ? SW'(prod_q[i]) :
                    acc_q[i] + SW'(prod_q[i]);
      end
    end
    fin_clamp_q <= prod_tag_q.clamp;
  end

  // Result queue.
  res_t push_res;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      push_res.pos[i] = round_sat(acc_q[i]);
    end
    push_res.clamped = fin_clamp_q;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      infl_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q  <= cnt_q + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
      infl_q <= infl_q + OUT_CNT_W'(eval_acc) - OUT_CNT_W'(push);
    end
  end

  res_t head;

  assign head        = fifo_q[rd_ptr_q];
  assign out_valid_o = cnt_q != '0;
  assign pos_x_o     = head.pos[0];
  assign pos_y_o     = head.pos[1];
  assign pos_z_o     = head.pos[2];
  assign t_clamped_o = head.clamped;

  // Checks.
  `QBSPE_ASSERT_NEVER(a_credit_bound, clk_i, rst_ni,
    ({1'b0, infl_q} + {1'b0, cnt_q}) > (OUT_CNT_W + 1)'(OUT_DEPTH),
    "results queued and in flight exceed the queue depth")
  `QBSPE_ASSERT_NEVER(a_push_full, clk_i, rst_ni,
    push && !pop && cnt_q == OUT_CNT_W'(OUT_DEPTH),
    "result pushed into a full queue")
  `QBSPE_ASSERT(a_read_order, clk_i, rst_ni,
    (iss_eval && iss_ph_q == PH_FIRST) |=> (iss_eval && iss_ph_q == PH_MID),
    "evaluate did not advance to its second read")
  `QBSPE_ASSERT(a_idle_ready, clk_i, rst_ni,
    (!iss_vld_q && infl_q == '0 && cnt_q == '0) |-> !in_stall_o,
    "input stalled while the block is empty")

endmodule

FILE: test/bspline_position_checker.sv
`timescale 1ns / 100ps

module bspline_position_checker #(
  parameter int MAX_POINTS = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        func_i,
  input  logic [7:0]  point_index_i,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic [31:0] coord_z_i,
  input  logic [23:0] param_t_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic        t_clamped_i,
  output int          mismatch_cnt_o,
  output int          positions_due_o,
  output int          positions_checked_o
);
  import qbspe_pkg::*;

  logic [8:0]         num_points;
  logic signed [31:0] pt_tab [3][MAX_POINTS];
  res_t               position_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_cnt_o++;
    if (mismatch_cnt_o <= 30) begin
      $display("ERROR at %0t ns: %s got %h, expected %h", $time, what, got, want);
    end
  endtask

  // Position on the clamped uniform quadratic curve, weights over 2*ONE*ONE.
  function automatic res_t predict_position(input logic [23:0] t_in);
    longint one, pts, dend, t, s, u, a, b, wx, wz, bx, by, bz, sum, r;
    res_t   res;
    one  = longint'(1) << FRAC_BITS;
    pts  = (num_points < 3) ? 3 : (num_points > MAX_POINTS) ? MAX_POINTS : num_points;
    t    = longint'(t_in);
    dend = (pts - 2) << FRAC_BITS;
    res.clamped = (t > dend);
    if (res.clamped) t = dend;
    s = t >> FRAC_BITS;
    u = t - (s << FRAC_BITS);
    // At the domain end the last span is used with u at its full value.
    if (s >= pts - 2) begin
      s = pts - 3;
      u = one;
    end
    a  = (s == 0) ? 2 * u : u + one;
    b  = (s == pts - 3) ? 2 * u : u;
    wx = (one - u) * (2 * one - a);
    wz = u * b;
    bx = (wx + one) >>> (FRAC_BITS + 1);
    bz = (wz + one) >>> (FRAC_BITS + 1);
    by = one - bx - bz;
    for (int c = 0; c < 3; c++) begin
      sum = bx * longint'(pt_tab[c][s]) + by * longint'(pt_tab[c][s + 1])
          + bz * longint'(pt_tab[c][s + 2]);
      r = (sum + one / 2) >>> FRAC_BITS;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      else if (r < -64'sd2147483648) r = -64'sd2147483648;
      res.pos[c] = r[31:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      num_points          = 9'd3;
      mismatch_cnt_o      = 0;
      positions_checked_o = 0;
      position_q.delete();
    end else begin
      if (cfg_we_i) num_points = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (position_q.size() == 0) begin
          report_mismatch("position with no evaluate request waiting", pos_x_i, '0);
        end else begin
          want = position_q.pop_front();
          positions_checked_o++;
          if (pos_x_i !== want.pos[0]) report_mismatch("pos_x", pos_x_i, want.pos[0]);
          if (pos_y_i !== want.pos[1]) report_mismatch("pos_y", pos_y_i, want.pos[1]);
          if (pos_z_i !== want.pos[2]) report_mismatch("pos_z", pos_z_i, want.pos[2]);
          if (t_clamped_i !== want.clamped) begin
            report_mismatch("t_clamped", 32'(t_clamped_i), 32'(want.clamped));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (func_i == FUNC_LOAD) begin
          pt_tab[0][point_index_i] = coord_x_i;
          pt_tab[1][point_index_i] = coord_y_i;
          pt_tab[2][point_index_i] = coord_z_i;
        end else begin
          position_q.push_back(predict_position(param_t_i));
        end
      end
    end
    positions_due_o = position_q.size();
  end

endmodule

FILE: test/quadratic_bspline_point_eval_unit_tb.sv
`timescale 1ns / 100ps

module quadratic_bspline_point_eval_unit_tb;
  import qbspe_pkg::*;

  localparam int HOLD_CYCLES = 90;
  localparam int SETTLE      = 12;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [8:0]  cfg_wdata   = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic        func        = FUNC_LOAD;
  logic [7:0]  point_index = '0;
  logic [31:0] coord_x     = '0;
  logic [31:0] coord_y     = '0;
  logic [31:0] coord_z     = '0;
  logic [23:0] param_t     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [31:0] pos_x, pos_y, pos_z;
  logic        t_clamped;

  int mismatch_cnt, positions_due, positions_checked;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_req  = 0;
  int hold_done = 0;
  int hold_left = 0;
  int load_cnt  = 0;
  int eval_cnt  = 0;
  logic [8:0] cur_cfg = 9'd3;
  bit loaded [256];

  // Point count and flow pattern of each random phase.
  int phase_cfg   [7] = '{256, 0, 5, 511, 40, 257, 3};
  int phase_idle  [7] = '{0, 84, 0, 28, 0, 84, 0};
  int phase_stall [7] = '{0, 0, 84, 28, 0, 0, 84};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  quadratic_bspline_point_eval_unit u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (func),
    .point_index_i(point_index),
    .coord_x_i    (coord_x),
    .coord_y_i    (coord_y),
    .coord_z_i    (coord_z),
    .param_t_i    (param_t),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pos_x_o      (pos_x),
    .pos_y_o      (pos_y),
    .pos_z_o      (pos_z),
    .t_clamped_o  (t_clamped)
  );

  bspline_position_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .func_i             (func),
    .point_index_i      (point_index),
    .coord_x_i          (coord_x),
    .coord_y_i          (coord_y),
    .coord_z_i          (coord_z),
    .param_t_i          (param_t),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .pos_x_i            (pos_x),
    .pos_y_i            (pos_y),
    .pos_z_i            (pos_z),
    .t_clamped_i        (t_clamped),
    .mismatch_cnt_o     (mismatch_cnt),
    .positions_due_o    (positions_due),
    .positions_checked_o(positions_checked)
  );

  // Result side: random stall, or a long hold-off when the stimulus asks for one.
  always @(negedge clk) begin
    if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_req(input logic f, input logic [7:0] idx, input logic [31:0] cx,
                          input logic [31:0] cy, input logic [31:0] cz,
                          input logic [23:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    func        = f;
    point_index = idx;
    coord_x     = cx;
    coord_y     = cy;
    coord_z     = cz;
    param_t     = t;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    if (f == FUNC_LOAD) begin
      loaded[idx] = 1'b1;
      load_cnt++;
    end else begin
      eval_cnt++;
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_point(input logic [7:0] idx);
    send_req(FUNC_LOAD, idx, rand_coord(), rand_coord(), rand_coord(), 24'($urandom));
  endtask

  task automatic eval_at(input logic [23:0] t);
    send_req(FUNC_EVAL, 8'($urandom), $urandom, $urandom, $urandom, t);
  endtask

  // Mostly evaluations of spans whose points are loaded; a span that still
  // has a hole gets the missing point loaded instead.
  task automatic random_req();
    int          n, s, miss;
    logic [23:0] t;
    logic [31:0] dend;
    n    = (cur_cfg < 3) ? 3 : (cur_cfg > 256) ? 256 : int'(cur_cfg);
    dend = 32'(n - 2) << 16;
    if ($urandom_range(99) < 25) begin
      load_point(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                          : 8'($urandom_range(n - 1)));
      return;
    end
    case ($urandom_range(9))
      0:       t = 24'($urandom_range(n - 2)) << 16;
      1:       t = dend[23:0];
      2:       t = 24'($urandom_range(32'hFF_FFFF, dend + 1));
      3:       t = 24'($urandom);
      default: t = 24'($urandom_range(dend));
    endcase
    s = (t > dend) ? n - 3 : int'(t >> 16);
    if (s > n - 3) s = n - 3;
    miss = -1;
    for (int k = 2; k >= 0; k--) begin
      if (!loaded[s + k]) miss = s + k;
    end
    if (miss < 0) eval_at(t);
    else load_point(8'(miss));
  endtask

  task automatic wait_drained();
    while (positions_due != 0) @(negedge clk);
  endtask

  task automatic set_points(input logic [8:0] v);
    wait_drained();
    // Loads return nothing, so give the last of them time to leave the pipe.
    repeat (SETTLE) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_cfg   = v;
  endtask

  initial begin
    #2000000;
    $display("Run timed out waiting on the block");
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part at the reset point count of three.
    send_req(FUNC_LOAD, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 24'hFF_FFFF);
    send_req(FUNC_LOAD, 8'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 24'h00_0000);
    send_req(FUNC_LOAD, 8'd2, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_req(FUNC_EVAL, 8'hFF, '1, '1, '1, 24'h00_0000);
    send_req(FUNC_EVAL, 8'h00, '0, '0, '0, 24'h00_0001);
    eval_at(24'h00_8000);
    eval_at(24'h00_FFFF);
    eval_at(24'h01_0000);
    eval_at(24'h01_0001);
    eval_at(24'hFF_FFFF);
    send_req(FUNC_LOAD, 8'hFF, $urandom, $urandom, $urandom, 24'h00_0000);
    for (int i = 0; i < 3; i++) begin
      send_req(FUNC_LOAD, 8'(i), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    end
    eval_at(24'h00_8000);
    for (int i = 0; i < 3; i++) begin
      send_req(FUNC_LOAD, 8'(i), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1);
    end
    eval_at(24'h00_4000);

    for (int p = 0; p < 7; p++) begin
      set_points(9'(phase_cfg[p]));
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int i = 0; i < 240; i++) begin
        // Receiver holds off while requests keep coming, filling the block.
        if (p == 4 && i == 60) hold_req++;
        // Sender pauses until every position has come back.
        if (p == 5 && i == 120) begin
          in_valid = 1'b0;
          wait_drained();
        end
        random_req();
      end
    end
    in_valid = 1'b0;
    idle_pct = 0;

    for (int w = 0; w < 20000 && positions_due != 0; w++) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Sent %0d point loads and %0d evaluations over seven point counts,",
             load_cnt, eval_cnt);
    $display("including out-of-range counts, knots, domain end and clamped t; %0d compared.",
             positions_checked);
    if (mismatch_cnt == 0 && positions_due == 0) begin
      $display("No mismatches found");
    end else begin
      if (positions_due != 0) begin
        $display("%0d evaluate requests never returned a position", positions_due);
      end
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/qbspe_pkg.sv
rtl/quadratic_bspline_point_eval_unit.sv
test/bspline_position_checker.sv
test/quadratic_bspline_point_eval_unit_tb.sv
